### src/rpf_pkg.sv
// Shared types, codes and constants of the rotated pixel frame store.
package rpf_pkg;

  localparam int DEF_PANEL_WIDTH  = 104;
  localparam int DEF_PANEL_HEIGHT = 212;

  localparam int COORD_W  = 11;
  localparam int BIDX_W   = 12;
  localparam int OPCODE_W = 2;
  localparam int DATA_W   = 8;
  localparam int APB_W    = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [OPCODE_W-1:0] OP_PLOT  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  localparam logic REG_ROTATION = 1'b0;
  localparam logic REG_INVERT   = 1'b1;

  localparam logic [1:0] ROTATION_RST = ROT_270;
  localparam logic       INVERT_RST   = 1'b0;

  localparam logic [DATA_W-1:0] PIXEL_MSB_MASK = 8'h80;
  localparam logic [DATA_W-1:0] BYTE_ZERO      = 8'h00;
  localparam logic [DATA_W-1:0] BYTE_ONES      = 8'hFF;

  typedef struct packed {
    logic [1:0] rotation;
    logic       invert_color;
  } cfg_t;

  function automatic int addr_w(int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

### src/rpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpf_ram
  import rpf_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic                      re,
  input  logic [addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word until the next read
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/rpf_xform.sv
// Rotation, bounds check and byte address / bit mask of one logical pixel.
module rpf_xform
  import rpf_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic [1:0]                  rotation,
  input  logic signed [COORD_W-1:0]   pos_x,
  input  logic signed [COORD_W-1:0]   pos_y,
  output logic                        hit,
  output logic [addr_w(((PANEL_WIDTH + 7) / 8) * PANEL_HEIGHT)-1:0] byte_addr,
  output logic [DATA_W-1:0]           bit_mask
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = addr_w(STORE_BYTES);

  localparam logic [COORD_W-1:0] W_L   = COORD_W'(PANEL_WIDTH);
  localparam logic [COORD_W-1:0] H_L   = COORD_W'(PANEL_HEIGHT);
  localparam logic [COORD_W-1:0] ONE_L = COORD_W'(1);
  localparam logic [ADDR_W-1:0]  ROW_L = ADDR_W'(ROW_BYTES);

  logic [COORD_W-1:0] ux, uy, ext_x, ext_y, px, py;

  always_comb begin
    ux = {1'b0, pos_x[COORD_W-2:0]};
    uy = {1'b0, pos_y[COORD_W-2:0]};
    ext_x = rotation[0] ? H_L : W_L;
    ext_y = rotation[0] ? W_L : H_L;
    hit = !pos_x[COORD_W-1] && !pos_y[COORD_W-1] && (ux < ext_x) && (uy < ext_y);
    unique case (rotation)
      ROT_0: begin
        px = ux;
        py = uy;
      end
      ROT_90: begin
        px = W_L - ONE_L - uy;
        py = ux;
      end
      ROT_180: begin
        px = W_L - ONE_L - ux;
        py = H_L - ONE_L - uy;
      end
      default: begin
        px = uy;
        py = H_L - ONE_L - ux;
      end
    endcase
    byte_addr = ADDR_W'(px[COORD_W-1:3]) + ADDR_W'(py) * ROW_L;
    bit_mask  = PIXEL_MSB_MASK >> px[2:0];
  end

endmodule

### src/rpf_cfg.sv
// APB register file: rotation and colour inversion.
module rpf_cfg
  import rpf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]      pwdata,
  output logic [APB_W-1:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_ROTATION: cfg_nxt.rotation     = pwdata[1:0];
        REG_INVERT:   cfg_nxt.invert_color = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROTATION: prdata = {{(APB_W-2){1'b0}}, cfg_r.rotation};
      REG_INVERT:   prdata = {{(APB_W-1){1'b0}}, cfg_r.invert_color};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation     <= ROTATION_RST;
      cfg_r.invert_color <= INVERT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/rotated_pixel_framebuffer.sv
// Rotated 1-bit-per-pixel frame store: top level with sequencer and output register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: plot a pixel,
//   clear the whole store to one colour, or read one packed byte.
//   Result channel (out_valid/out_ready) returns exactly one result per
//   request: read_byte (zero except for an in-range read) and accepted.
//   Configuration goes through the APB port (rotation at 0x0, invert at 0x4).
// Sequencing:
//   Plot and read: the byte is fetched from the store as the request is
//   taken, then modified, written back and its result registered in ST_MOD
//   once the output register is free; no new request is taken until then.
//   Dropped requests pass through ST_RESP. Clear sweeps the store one byte
//   per cycle in ST_SWEEP, then passes through ST_RESP.
// Reset:
//   rst_n is synchronous. Afterwards the store is swept to zero, one byte
//   per cycle; in_ready stays low meanwhile, APB writes are taken as ever.
// Stall:
//   A request is taken while the previous result waits in the output
//   register; its result is held back until the register frees.
module rotated_pixel_framebuffer
  import rpf_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic                      in_colored,
  input  logic [BIDX_W-1:0]         in_byte_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [DATA_W-1:0]         out_read_byte,
  output logic                      out_accepted,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [APB_W-1:0]          cfg_pwdata,
  output logic [APB_W-1:0]          cfg_prdata,
  output logic                      cfg_pready
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = addr_w(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_RESP  = 3'd4;

  cfg_t cfg;

  logic [2:0]          state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [DATA_W-1:0]   mask_r, mask_nxt;
  logic [DATA_W-1:0]   fill_r, fill_nxt;
  logic                set_r, set_nxt;
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic                resp_acc_r, resp_acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_byte_r;
  logic                out_acc_r;

  logic                xf_hit;
  logic [ADDR_W-1:0]   xf_addr;
  logic [DATA_W-1:0]   xf_mask;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [DATA_W-1:0]   ram_wdata, ram_rdata;

  logic                out_free, load_out, rd_hit, set_bit;
  logic [DATA_W-1:0]   res_byte;
  logic                res_acc;

  rpf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rpf_xform #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_xform (
    .rotation  (cfg.rotation),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .hit       (xf_hit),
    .byte_addr (xf_addr),
    .bit_mask  (xf_mask)
  );

  rpf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;
  assign set_bit  = (in_colored == cfg.invert_color);
  assign rd_hit   = ({{(32-BIDX_W){1'b0}}, in_byte_index} < 32'(STORE_BYTES));

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    fill_nxt     = fill_r;
    set_nxt      = set_r;
    op_nxt       = op_r;
    resp_acc_nxt = resp_acc_r;
    ram_we       = 1'b0;
    ram_waddr    = cnt_r;
    ram_wdata    = fill_r;
    ram_re       = 1'b0;
    ram_raddr    = xf_addr;
    load_out     = 1'b0;
    res_byte     = BYTE_ZERO;
    res_acc      = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BYTE_ZERO;
        cnt_nxt   = cnt_r + ADDR_ONE;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_opcode;
          resp_acc_nxt = 1'b0;
          state_nxt    = ST_RESP;
          unique case (in_opcode)
            OP_PLOT: begin
              if (xf_hit) begin
                ram_re    = 1'b1;
                addr_nxt  = xf_addr;
                mask_nxt  = xf_mask;
                set_nxt   = set_bit;
                state_nxt = ST_MOD;
              end
            end
            OP_CLEAR: begin
              fill_nxt  = set_bit ? BYTE_ONES : BYTE_ZERO;
              cnt_nxt   = '0;
              state_nxt = ST_SWEEP;
            end
            OP_READ: begin
              if (rd_hit) begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(in_byte_index);
                state_nxt = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        // hold the fetched byte until the output register frees
        if (out_free) begin
          load_out  = 1'b1;
          res_acc   = 1'b1;
          state_nxt = ST_IDLE;
          if (op_r == OP_READ) begin
            res_byte = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = addr_r;
            ram_wdata = set_r ? (ram_rdata | mask_r) : (ram_rdata & ~mask_r);
          end
        end
      end
      ST_SWEEP: begin
        ram_we  = 1'b1;
        cnt_nxt = cnt_r + ADDR_ONE;
        if (cnt_r == LAST_ADDR) begin
          cnt_nxt      = '0;
          resp_acc_nxt = 1'b1;
          state_nxt    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load_out  = 1'b1;
          res_acc   = resp_acc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    fill_r     <= fill_nxt;
    set_r      <= set_nxt;
    op_r       <= op_nxt;
    resp_acc_r <= resp_acc_nxt;
    if (load_out) begin
      out_byte_r <= res_byte;
      out_acc_r  <= res_acc;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;
  assign out_accepted  = out_acc_r;

endmodule

### src/rpf_checker.sv
// Port-level checks of the rotated pixel frame store, bound to the top level.
module rpf_checker
  import rpf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_read_byte,
  input logic              out_accepted,
  input logic              cfg_pready
);

  // a non-zero byte only comes from a read that hit the store
  a_byte_implies_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_byte != BYTE_ZERO) |-> out_accepted)
    else $error("non-zero read_byte on a dropped request");

  // the store sweep after reset keeps the input closed and no result pending
  a_reset_sweep: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !in_ready && !out_valid)
    else $error("block open or result pending straight after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte) && $stable(out_accepted))
    else $error("stalled result dropped or changed");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind rotated_pixel_framebuffer rpf_checker u_rpf_checker (.*);
